@@ sv/scas_pkg.sv @@
// ----------------------------------------------------------------------------
// Sprite clip sequencer package
// Shared widths, codes, register and command types, and clip lookup functions.
// ----------------------------------------------------------------------------
package scas_pkg;

  localparam int NUM_CLIPS  = 11;
  localparam int MAX_FRAMES = 31;
  localparam int CLIP_W     = 4;
  localparam int FRAME_W    = 5;
  localparam int FIELD_W    = 5;
  localparam int CFG_W      = 55;
  localparam int LOOP_W     = 11;
  localparam int IVL_W      = 10;
  localparam int TIME_W     = 32;
  localparam int KIND_W     = 2;
  localparam int DATA_W     = 64;
  localparam int ADDR_W     = 5;
  localparam int IDX_LSB    = 3;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK = 2'd0,
    KIND_SET  = 2'd1,
    KIND_PLAY = 2'd2
  } kind_e;

  typedef enum logic [ADDR_W-IDX_LSB-1:0] {
    REG_COUNTS = 2'd0,
    REG_RATES  = 2'd1,
    REG_LOOPS  = 2'd2
  } reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic [CFG_W-1:0]  counts;
    logic [CFG_W-1:0]  rates;
    logic [LOOP_W-1:0] loops;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic exec;
  } cmd_t;

  function automatic logic [CLIP_W-1:0] clamp_clip(input logic [CLIP_W-1:0] c);
    logic [CLIP_W-1:0] r;
    r = c;
    if (int'(c) >= NUM_CLIPS) r = '0;
    return r;
  endfunction

  function automatic logic [FIELD_W-1:0] field_of(input logic [CFG_W-1:0] reg_v,
                                                  input logic [CLIP_W-1:0] c);
    logic [FIELD_W-1:0] r;
    r = '0;
    for (int i = 0; i < NUM_CLIPS; i++) begin
      if (int'(c) == i) r = reg_v[FIELD_W*i +: FIELD_W];
    end
    return r;
  endfunction

  function automatic logic [FRAME_W-1:0] count_of(input logic [CFG_W-1:0] counts,
                                                  input logic [CLIP_W-1:0] c);
    logic [FIELD_W-1:0] n;
    n = field_of(counts, c);
    if (int'(n) > MAX_FRAMES) n = FIELD_W'(MAX_FRAMES);
    return FRAME_W'(n);
  endfunction

  function automatic logic [IVL_W-1:0] interval_of(input logic [FIELD_W-1:0] fps);
    logic [IVL_W-1:0] r;
    case (fps)
      5'd0:    r = 10'd500;
      5'd1:    r = 10'd1000;
      5'd2:    r = 10'd500;
      5'd3:    r = 10'd333;
      5'd4:    r = 10'd250;
      5'd5:    r = 10'd200;
      5'd6:    r = 10'd166;
      5'd7:    r = 10'd142;
      5'd8:    r = 10'd125;
      5'd9:    r = 10'd111;
      5'd10:   r = 10'd100;
      5'd11:   r = 10'd90;
      5'd12:   r = 10'd83;
      5'd13:   r = 10'd76;
      5'd14:   r = 10'd71;
      5'd15:   r = 10'd66;
      5'd16:   r = 10'd62;
      5'd17:   r = 10'd58;
      5'd18:   r = 10'd55;
      5'd19:   r = 10'd52;
      5'd20:   r = 10'd50;
      5'd21:   r = 10'd47;
      5'd22:   r = 10'd45;
      5'd23:   r = 10'd43;
      5'd24:   r = 10'd41;
      5'd25:   r = 10'd40;
      5'd26:   r = 10'd38;
      5'd27:   r = 10'd37;
      5'd28:   r = 10'd35;
      5'd29:   r = 10'd34;
      5'd30:   r = 10'd33;
      default: r = 10'd32;
    endcase
    return r;
  endfunction

endpackage

@@ sv/scas_if.sv @@
// ----------------------------------------------------------------------------
// Sprite clip sequencer channels
// Valid/ready request channel and result channel with their payloads.
// ----------------------------------------------------------------------------
interface scas_in_if;
  logic                            valid;
  logic                            ready;
  logic [scas_pkg::KIND_W-1:0]     kind;
  logic [scas_pkg::TIME_W-1:0]     now_ms;
  logic [scas_pkg::CLIP_W-1:0]     target_clip;
  logic [scas_pkg::CLIP_W-1:0]     return_clip;

  modport source (output valid, kind, now_ms, target_clip, return_clip, input ready);
  modport sink   (input valid, kind, now_ms, target_clip, return_clip, output ready);
endinterface

interface scas_out_if;
  logic                            valid;
  logic                            ready;
  logic                            shown;
  logic [scas_pkg::CLIP_W-1:0]     clip;
  logic [scas_pkg::FRAME_W-1:0]    frame;

  modport source (output valid, shown, clip, frame, input ready);
  modport sink   (input valid, shown, clip, frame, output ready);
endinterface

@@ sv/scas_regs.sv @@
// ----------------------------------------------------------------------------
// Sprite clip sequencer configuration registers
// APB-style write/read port for frame counts, frame rates and loop flags.
// ----------------------------------------------------------------------------
module scas_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scas_pkg::ADDR_W-1:0]   paddr,
  input  logic [scas_pkg::DATA_W-1:0]   pwdata,
  output logic [scas_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  output scas_pkg::cfg_t                cfg_o
);

  logic [scas_pkg::CFG_W-1:0]  counts_q;
  logic [scas_pkg::CFG_W-1:0]  rates_q;
  logic [scas_pkg::LOOP_W-1:0] loops_q;
  logic                        wr_en;
  scas_pkg::reg_e              idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign idx    = scas_pkg::reg_e'(paddr[scas_pkg::ADDR_W-1:scas_pkg::IDX_LSB]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      counts_q <= '0;
      rates_q  <= '0;
      loops_q  <= '0;
    end else if (wr_en) begin
      case (idx)
        scas_pkg::REG_COUNTS: counts_q <= pwdata[scas_pkg::CFG_W-1:0];
        scas_pkg::REG_RATES:  rates_q  <= pwdata[scas_pkg::CFG_W-1:0];
        scas_pkg::REG_LOOPS:  loops_q  <= pwdata[scas_pkg::LOOP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      scas_pkg::REG_COUNTS: prdata = scas_pkg::DATA_W'(counts_q);
      scas_pkg::REG_RATES:  prdata = scas_pkg::DATA_W'(rates_q);
      scas_pkg::REG_LOOPS:  prdata = scas_pkg::DATA_W'(loops_q);
      default:              prdata = '0;
    endcase
  end

  assign cfg_o.counts = counts_q;
  assign cfg_o.rates  = rates_q;
  assign cfg_o.loops  = loops_q;

endmodule

@@ sv/scas_ctrl.sv @@
// ----------------------------------------------------------------------------
// Sprite clip sequencer controller
// Two-state sequencer: capture and lookup, then execute into the result register.
// ----------------------------------------------------------------------------
module scas_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output scas_pkg::cmd_t  cmd_o
);

  scas_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;
  logic             out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= scas_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    in_ready_o  = 1'b0;
    cmd_o.load  = 1'b0;
    cmd_o.exec  = 1'b0;
    out_free    = !out_valid_q || out_ready_i;
    case (state_q)
      scas_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = scas_pkg::ST_EXEC;
        end
      end
      scas_pkg::ST_EXEC: begin
        // hold the request until the result slot is free
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = scas_pkg::ST_IDLE;
        end
      end
      default: state_d = scas_pkg::ST_IDLE;
    endcase
    if (cmd_o.exec) out_valid_d = 1'b1;
    else if (out_ready_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ sv/scas_dp.sv @@
// ----------------------------------------------------------------------------
// Sprite clip sequencer datapath
// Request capture, clip lookups, sequencer state and result register.
// ----------------------------------------------------------------------------
module scas_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  scas_pkg::cmd_t                cmd_i,
  input  scas_pkg::cfg_t                cfg_i,
  input  logic [scas_pkg::KIND_W-1:0]   kind_i,
  input  logic [scas_pkg::TIME_W-1:0]   now_ms_i,
  input  logic [scas_pkg::CLIP_W-1:0]   target_clip_i,
  input  logic [scas_pkg::CLIP_W-1:0]   return_clip_i,
  output logic                          shown_o,
  output logic [scas_pkg::CLIP_W-1:0]   clip_o,
  output logic [scas_pkg::FRAME_W-1:0]  frame_o
);

  localparam int CW = scas_pkg::CLIP_W;
  localparam int FW = scas_pkg::FRAME_W;
  localparam int TW = scas_pkg::TIME_W;

  // sequencer state
  logic [CW-1:0] active_q, active_d;
  logic [CW-1:0] pending_q, pending_d;
  logic [FW-1:0] fp_q, fp_d;
  logic          os_q, os_d;
  logic          started_q, started_d;
  logic [TW-1:0] last_q, last_d;

  // captured request and lookups
  logic [scas_pkg::KIND_W-1:0] kind_q;
  logic [TW-1:0]               now_q;
  logic [CW-1:0]               tgt_q;
  logic [CW-1:0]               ret_q;
  logic [FW-1:0]               cnt_act_q;
  logic [FW-1:0]               cnt_tgt_q;
  logic [FW-1:0]               cnt_pend_q;
  logic [scas_pkg::IVL_W-1:0]  ivl_q;
  logic                        loop_q;
  logic                        ge_q;

  logic                        shown_q;
  logic [CW-1:0]               out_clip_q;
  logic [FW-1:0]               out_frame_q;

  logic [CW-1:0]               tgt_c;
  logic [scas_pkg::IVL_W-1:0]  ivl_c;
  logic [TW-1:0]               elapsed_c;
  logic                        shown_d;
  logic                        enter_pend;
  logic [FW:0]                 next_fp;

  assign tgt_c     = scas_pkg::clamp_clip(target_clip_i);
  assign ivl_c     = scas_pkg::interval_of(scas_pkg::field_of(cfg_i.rates, active_q));
  assign elapsed_c = now_ms_i - last_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q     <= kind_i;
      now_q      <= now_ms_i;
      tgt_q      <= tgt_c;
      ret_q      <= scas_pkg::clamp_clip(return_clip_i);
      cnt_act_q  <= scas_pkg::count_of(cfg_i.counts, active_q);
      cnt_tgt_q  <= scas_pkg::count_of(cfg_i.counts, tgt_c);
      cnt_pend_q <= scas_pkg::count_of(cfg_i.counts, pending_q);
      ivl_q      <= ivl_c;
      loop_q     <= cfg_i.loops[active_q];
      ge_q       <= elapsed_c >= TW'(ivl_c);
    end
    if (cmd_i.exec) begin
      shown_q     <= shown_d;
      out_clip_q  <= active_d;
      out_frame_q <= fp_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q  <= '0;
      pending_q <= '0;
      fp_q      <= '0;
      os_q      <= 1'b0;
      started_q <= 1'b0;
      last_q    <= '0;
    end else if (cmd_i.exec) begin
      active_q  <= active_d;
      pending_q <= pending_d;
      fp_q      <= fp_d;
      os_q      <= os_d;
      started_q <= started_d;
      last_q    <= last_d;
    end
  end

  always_comb begin
    active_d   = active_q;
    pending_d  = pending_q;
    fp_d       = fp_q;
    os_d       = os_q;
    started_d  = started_q;
    last_d     = last_q;
    shown_d    = 1'b0;
    enter_pend = 1'b0;
    next_fp    = {1'b0, fp_q} + (FW+1)'(1);
    case (scas_pkg::kind_e'(kind_q))
      scas_pkg::KIND_TICK: begin
        if (cnt_act_q == '0) begin
        end else if (cnt_act_q == FW'(1)) begin
          if (os_q && ge_q) enter_pend = 1'b1;
        end else if (!loop_q && !os_q && (next_fp >= {1'b0, cnt_act_q})) begin
        end else if (ge_q) begin
          last_d = last_q + TW'(ivl_q);
          if (next_fp >= {1'b0, cnt_act_q}) begin
            if (os_q) begin
              fp_d       = next_fp[FW] ? '1 : next_fp[FW-1:0];
              enter_pend = 1'b1;
            end else begin
              fp_d    = loop_q ? '0 : cnt_act_q - FW'(1);
              shown_d = 1'b1;
            end
          end else begin
            fp_d    = next_fp[FW-1:0];
            shown_d = 1'b1;
          end
        end
      end
      scas_pkg::KIND_SET: begin
        if (!(started_q && (tgt_q == active_q) && !os_q)) begin
          active_d  = tgt_q;
          started_d = 1'b1;
          os_d      = 1'b0;
          fp_d      = '0;
          last_d    = now_q;
          shown_d   = cnt_tgt_q != '0;
        end
      end
      scas_pkg::KIND_PLAY: begin
        active_d  = tgt_q;
        pending_d = ret_q;
        os_d      = 1'b1;
        fp_d      = '0;
        last_d    = now_q;
        shown_d   = cnt_tgt_q != '0;
      end
      default: begin
      end
    endcase
    // one-shot done: switch to the return clip unless it is already running
    if (enter_pend) begin
      os_d = 1'b0;
      if (!(started_q && (pending_q == active_q))) begin
        active_d  = pending_q;
        started_d = 1'b1;
        fp_d      = '0;
        last_d    = now_q;
        shown_d   = cnt_pend_q != '0;
      end
    end
  end

  assign shown_o = shown_q;
  assign clip_o  = out_clip_q;
  assign frame_o = out_frame_q;

endmodule

@@ sv/sprite_clip_animation_sequencer.sv @@
// ----------------------------------------------------------------------------
// Sprite clip animation sequencer
// Frame sequencer for configurable sprite clips, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  : request channel (kind, now_ms, target_clip, return_clip),
//           valid/ready; a request is taken when both are high.
//   out_o : result channel (shown, clip, frame), valid/ready.
//   APB   : 64-bit bus, registers at 0x00 frame counts, 0x08 frame rates,
//           0x10 loop flags; pready is tied high. Write only while idle.
// Sequence:
//   The accept cycle captures a request together with the clip lookups
//   and elapsed-time compare; the execute step then updates the
//   sequencer state and loads the result register once the result slot is
//   free. No new request is taken until the execute step has run.
// Stall:
//   A waiting result does not block the next accept; that request holds in
//   the execute step until the result register is taken.
// Reset:
//   Config, clip and timer state clear to zero; capture/result regs not reset.
// ----------------------------------------------------------------------------
module sprite_clip_animation_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [scas_pkg::ADDR_W-1:0]   paddr,
  input  logic [scas_pkg::DATA_W-1:0]   pwdata,
  output logic [scas_pkg::DATA_W-1:0]   prdata,
  output logic                          pready,
  scas_in_if.sink                       in_i,
  scas_out_if.source                    out_o
);

  scas_pkg::cfg_t cfg;
  scas_pkg::cmd_t cmd;

  scas_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  scas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  scas_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .cfg_i         (cfg),
    .kind_i        (in_i.kind),
    .now_ms_i      (in_i.now_ms),
    .target_clip_i (in_i.target_clip),
    .return_clip_i (in_i.return_clip),
    .shown_o       (out_o.shown),
    .clip_o        (out_o.clip),
    .frame_o       (out_o.frame)
  );

endmodule

@@ sv/scas_sva.sv @@
// ----------------------------------------------------------------------------
// Sprite clip sequencer checker
// Port-level properties of the request and result channels.
// ----------------------------------------------------------------------------
module scas_sva (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_ready_i,
  input  logic                          out_valid_i,
  input  logic                          out_ready_i,
  input  logic                          out_shown_i,
  input  logic [scas_pkg::CLIP_W-1:0]   out_clip_i,
  input  logic [scas_pkg::FRAME_W-1:0]  out_frame_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_shown_i) && $stable(out_clip_i) && $stable(out_frame_i))
    else $error("result changed while stalled");

  a_no_b2b: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("request taken while previous one executes");

  a_clip_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (int'(out_clip_i) < scas_pkg::NUM_CLIPS))
    else $error("result clip out of range");

endmodule

bind sprite_clip_animation_sequencer scas_sva u_sva (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_shown_i (out_o.shown),
  .out_clip_i  (out_o.clip),
  .out_frame_i (out_o.frame)
);
